// ===== src/fmpc_pkg.sv =====
package fmpc_pkg;

    localparam int unsigned CFG_INDEX_W = 2;
    localparam int unsigned CFG_DATA_W  = 32;

    localparam logic [CFG_INDEX_W-1:0] REG_BLACK_FRAME = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_MODE_CODES  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_DUTY_TABLE  = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_SILENCE_LIM = 2'd3;

    localparam logic [7:0]  BLACK_FRAME_RST = 8'd200;
    localparam logic [31:0] MODE_CODES_RST  = 32'd252446208;
    localparam logic [15:0] DUTY_TABLE_RST  = 16'd13104;
    localparam logic [15:0] SILENCE_LIM_RST = 16'd1000;

    localparam logic [1:0] MODE_HAZE  = 2'd0;
    localparam logic [1:0] MODE_CLEAR = 2'd3;

    localparam logic [15:0] SILENCE_MAX = 16'hFFFF;

    typedef struct packed {
        logic [7:0]  black_frame_periods;
        logic [31:0] mode_code_table;
        logic [15:0] duty_table;
        logic [15:0] silence_limit;
    } cfg_t;

    typedef struct packed {
        logic       haze_pressed;
        logic       clear_pressed;
        logic       byte_arrived;
    } tick_in_t;

    typedef struct packed {
        logic       pwm_level;
        logic       mode_changed;
        logic [1:0] new_mode;
        logic [7:0] film_command;
        logic       link_lost;
    } result_t;

endpackage

// ===== src/film_mode_pwm_controller.sv =====
// Film-mode backlight PWM controller. Each accepted input word is one timer
// tick and yields exactly one result word, one tick per clock cycle while
// s_ready is high; the result word is offered on the cycle after its tick is
// accepted unless an earlier word waits on m_ready; a two-word buffer lets
// input run on while m_ready is low until it is full, then stalls s_ready.
// A switch to a film mode holds the backlight fully on for the rest of the
// current PWM period, black_frame_periods further periods and the first tick
// of the next one, reports the mode's command code with mode_changed, then
// applies the mode's duty. After reset the block sits in
// the black frame of a switch to the clear mode. Configuration writes are
// always accepted (cfg_ready is tied high) and must only be issued while no
// result is pending.
module film_mode_pwm_controller #(
    parameter int unsigned PWM_PERIOD = 10
) (
    input  logic                               aclk,
    input  logic                               aresetn,

    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic                               s_haze_pressed,
    input  logic                               s_clear_pressed,
    input  logic                               s_byte_arrived,

    output logic                               m_valid,
    input  logic                               m_ready,
    output logic                               m_pwm_level,
    output logic                               m_mode_changed,
    output logic [1:0]                         m_new_mode,
    output logic [7:0]                         m_film_command,
    output logic                               m_link_lost,

    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [fmpc_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [fmpc_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import fmpc_pkg::*;

    cfg_t     cfg_reg;
    tick_in_t tick_in;
    result_t  core_result;
    result_t  out_result;
    logic     accept;
    logic     can_push;

    assign cfg_ready = 1'b1;
    assign s_ready   = can_push;
    assign accept    = s_valid && can_push;

    assign tick_in.haze_pressed  = s_haze_pressed;
    assign tick_in.clear_pressed = s_clear_pressed;
    assign tick_in.byte_arrived  = s_byte_arrived;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.black_frame_periods <= BLACK_FRAME_RST;
            cfg_reg.mode_code_table     <= MODE_CODES_RST;
            cfg_reg.duty_table          <= DUTY_TABLE_RST;
            cfg_reg.silence_limit       <= SILENCE_LIM_RST;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_BLACK_FRAME: cfg_reg.black_frame_periods <= cfg_data[7:0];
                REG_MODE_CODES:  cfg_reg.mode_code_table     <= cfg_data[31:0];
                REG_DUTY_TABLE:  cfg_reg.duty_table          <= cfg_data[15:0];
                REG_SILENCE_LIM: cfg_reg.silence_limit       <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    fmpc_core #(
        .PWM_PERIOD (PWM_PERIOD)
    ) u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .tick_valid (accept),
        .tick_in    (tick_in),
        .cfg        (cfg_reg),
        .result     (core_result)
    );

    fmpc_outbuf u_outbuf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (accept),
        .push_data (core_result),
        .can_push  (can_push),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (out_result)
    );

    assign m_pwm_level    = out_result.pwm_level;
    assign m_mode_changed = out_result.mode_changed;
    assign m_new_mode     = out_result.new_mode;
    assign m_film_command = out_result.film_command;
    assign m_link_lost    = out_result.link_lost;

`ifndef SYNTHESIS
    a_accept_gives_word: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> m_valid)
        else $error("accepted tick produced no result word");

    a_stall_means_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid)
        else $error("input stalled while output buffer empty");

    a_fallback_is_switch: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_link_lost |-> m_mode_changed && m_new_mode == MODE_CLEAR)
        else $error("link fallback without switch to clear mode");

    a_no_cmd_without_switch: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_mode_changed |-> m_film_command == 8'd0)
        else $error("command code without mode switch");
`endif

endmodule

// ===== src/fmpc_core.sv =====
module fmpc_core #(
    parameter int unsigned PWM_PERIOD = 10
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             tick_valid,
    input  fmpc_pkg::tick_in_t tick_in,
    input  fmpc_pkg::cfg_t   cfg,
    output fmpc_pkg::result_t result
);
    import fmpc_pkg::*;

    localparam logic [3:0] PERIOD = 4'(PWM_PERIOD);

    logic [3:0]  tick_reg, tick_next, tick_wrapped;
    logic [7:0]  period_reg, period_next, period_wrapped;
    logic        switching_reg, switching_next;
    logic [3:0]  duty_reg, duty_next;
    logic [1:0]  mode_reg, mode_next;
    logic [15:0] silence_reg, silence_next;
    logic        link_reg, link_next;
    logic        wrap;
    logic        changed;
    logic        lost;
    logic [7:0]  cmd;

    always_comb begin
        wrap           = (tick_reg >= PERIOD);
        tick_wrapped   = wrap ? 4'd0 : tick_reg;
        period_wrapped = wrap ? period_reg + 8'd1 : period_reg;

        period_next    = period_wrapped;
        switching_next = switching_reg;
        duty_next      = duty_reg;
        mode_next      = mode_reg;
        link_next      = link_reg;
        changed        = 1'b0;
        lost           = 1'b0;
        cmd            = 8'd0;

        if (switching_reg) begin
            if (period_wrapped > cfg.black_frame_periods) begin
                switching_next = 1'b0;
                duty_next      = cfg.duty_table[{mode_reg, 2'b00} +: 4];
            end
        end else if (tick_in.haze_pressed || tick_in.clear_pressed) begin
            mode_next      = tick_in.haze_pressed ? MODE_HAZE : MODE_CLEAR;
            switching_next = 1'b1;
            period_next    = 8'd0;
            duty_next      = PERIOD;
            changed        = 1'b1;
            cmd            = cfg.mode_code_table[{mode_next, 3'b000} +: 8];
        end

        if (tick_in.byte_arrived) begin
            silence_next = 16'd0;
            link_next    = 1'b1;
        end else if (silence_reg != SILENCE_MAX) begin
            silence_next = silence_reg + 16'd1;
        end else begin
            silence_next = silence_reg;
        end

        // fallback overrides any button switch on the same tick
        if (silence_next > cfg.silence_limit && link_next) begin
            mode_next      = MODE_CLEAR;
            switching_next = 1'b1;
            period_next    = 8'd0;
            duty_next      = PERIOD;
            link_next      = 1'b0;
            changed        = 1'b1;
            lost           = 1'b1;
            cmd            = cfg.mode_code_table[{MODE_CLEAR, 3'b000} +: 8];
        end

        tick_next = tick_wrapped + 4'd1;

        result.pwm_level    = (tick_wrapped < duty_reg);
        result.mode_changed = changed;
        result.new_mode     = mode_next;
        result.film_command = cmd;
        result.link_lost    = lost;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tick_reg      <= 4'd0;
            period_reg    <= 8'd0;
            switching_reg <= 1'b1;
            duty_reg      <= PERIOD;
            mode_reg      <= MODE_CLEAR;
            silence_reg   <= 16'd0;
            link_reg      <= 1'b0;
        end else if (tick_valid) begin
            tick_reg      <= tick_next;
            period_reg    <= period_next;
            switching_reg <= switching_next;
            duty_reg      <= duty_next;
            mode_reg      <= mode_next;
            silence_reg   <= silence_next;
            link_reg      <= link_next;
        end
    end

endmodule

// ===== src/fmpc_outbuf.sv =====
module fmpc_outbuf (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  fmpc_pkg::result_t push_data,
    output logic              can_push,
    output logic              out_valid,
    input  logic              out_ready,
    output fmpc_pkg::result_t out_data
);
    import fmpc_pkg::*;

    logic    out_valid_reg;
    logic    skid_valid_reg;
    result_t out_reg;
    result_t skid_reg;

    assign can_push  = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!out_valid_reg || out_ready) begin
            out_valid_reg  <= skid_valid_reg || push;
            skid_valid_reg <= 1'b0;
        end else if (push) begin
            skid_valid_reg <= 1'b1;
        end
    end

    // payload: drain the skid word first, else take the fresh word
    always_ff @(posedge aclk) begin
        if (!out_valid_reg || out_ready) begin
            if (skid_valid_reg) begin
                out_reg <= skid_reg;
            end else if (push) begin
                out_reg <= push_data;
            end
        end else if (push) begin
            skid_reg <= push_data;
        end
    end

endmodule
